// File: src/ccc_pkg.sv
`default_nettype none

package ccc_pkg;

	// Field widths
	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 16;

	// Command codes
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SET  = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	// Rollover and validation limits
	localparam logic [SEC_W:0]   SEC_WRAP     = 7'd60;
	localparam logic [MIN_W:0]   MIN_WRAP     = 7'd60;
	localparam logic [HOUR_W:0]  HOUR_WRAP    = 6'd24;
	localparam logic [MONTH_W:0] MONTH_LAST   = 5'd12;
	localparam logic [MIN_W-1:0]   MIN_MAX    = 6'd59;
	localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
	localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;

	// Month numbers with short months
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

	localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
	localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
	localparam logic [DAY_W-1:0] DAYS_LEAP  = 5'd29;
	localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;

	// Days in a month; every year divisible by four is a leap year
	function automatic logic [DAY_W-1:0] month_length(
		input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0]  year
	);
		logic [DAY_W-1:0] len;
		case (month)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
			MONTH_FEB: len = (year[1:0] == 2'b00) ? DAYS_LEAP : DAYS_FEB;
			default: len = DAYS_LONG;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// File: src/calendar_clock_counter.sv
`default_nettype none

// Calendar clock: keeps seconds, minutes, hours, day, month and year in one
// set of registers. A tick item adds a second and carries up to the year, a
// set item loads the time (rejected and flagged when minutes, hours or month
// are out of range), a read item changes nothing. One item is taken every
// cycle while in_stall is low; its result appears on the output in the next
// cycle and reports the time after that item. The whole carry chain settles
// combinationally ahead of the time registers, which double as the result
// register. Input stall rises only while a result waits and the output side stalls.
module calendar_clock_counter
	import ccc_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  [1:0]            cmd,
	input  wire  [SEC_W-1:0]      new_seconds,
	input  wire  [MIN_W-1:0]      new_minutes,
	input  wire  [HOUR_W-1:0]     new_hours,
	input  wire  [DAY_W-1:0]      new_day,
	input  wire  [MONTH_W-1:0]    new_month,
	input  wire  [YEAR_W-1:0]     new_year,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [SEC_W-1:0]      cur_seconds,
	output logic [MIN_W-1:0]      cur_minutes,
	output logic [HOUR_W-1:0]     cur_hours,
	output logic [DAY_W-1:0]      cur_day,
	output logic [MONTH_W-1:0]    cur_month,
	output logic [YEAR_W-1:0]     cur_year,
	output logic                  set_rejected
);

	logic [SEC_W-1:0]   sec_q;
	logic [MIN_W-1:0]   min_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic               rejected_q;
	logic               valid_q;

	logic               accept;
	logic [SEC_W:0]     sec_inc;
	logic [MIN_W:0]     min_inc;
	logic [HOUR_W:0]    hour_inc;
	logic [DAY_W:0]     day_inc;
	logic [MONTH_W:0]   month_inc;
	logic [YEAR_W-1:0]  year_inc;

	logic [SEC_W-1:0]   tick_sec;
	logic [MIN_W-1:0]   tick_min;
	logic [HOUR_W-1:0]  tick_hour;
	logic [DAY_W-1:0]   tick_day;
	logic [MONTH_W-1:0] tick_month;
	logic [YEAR_W-1:0]  tick_year;
	logic               set_bad;

	assign in_stall = valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Work out the time one second later
	always_comb begin
		sec_inc    = {1'b0, sec_q} + 1'b1;
		tick_sec   = sec_inc[SEC_W-1:0];
		tick_min   = min_q;
		tick_hour  = hour_q;
		tick_day   = day_q;
		tick_month = month_q;
		tick_year  = year_q;
		min_inc    = {1'b0, min_q} + 1'b1;
		hour_inc   = {1'b0, hour_q};
		day_inc    = {1'b0, day_q};
		month_inc  = {1'b0, month_q};
		year_inc   = year_q + 1'b1;
		if (sec_inc >= SEC_WRAP) begin
			tick_sec = '0;
			// minute step; hour, day and month checks run on every step
			tick_min = min_inc[MIN_W-1:0];
			if (min_inc >= MIN_WRAP) begin
				tick_min = '0;
				hour_inc = {1'b0, hour_q} + 1'b1;
			end
			tick_hour = hour_inc[HOUR_W-1:0];
			if (hour_inc >= HOUR_WRAP) begin
				tick_hour = '0;
				day_inc   = {1'b0, day_q} + 1'b1;
			end
			tick_day = day_inc[DAY_W-1:0];
			if (day_inc > {1'b0, month_length(month_q, year_q)}) begin
				tick_day  = DAY_W'(1);
				month_inc = {1'b0, month_q} + 1'b1;
			end
			tick_month = month_inc[MONTH_W-1:0];
			if (month_inc > MONTH_LAST) begin
				tick_month = MONTH_W'(1);
				tick_year  = year_inc;
			end
		end
	end

	// Validate a set item
	assign set_bad = (new_hours > HOUR_MAX) | (new_minutes > MIN_MAX) |
		(new_month > MONTH_MAX);

	// Advance the time registers and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q      <= '0;
			min_q      <= '0;
			hour_q     <= '0;
			day_q      <= '0;
			month_q    <= '0;
			year_q     <= '0;
			rejected_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				valid_q    <= 1'b1;
				rejected_q <= 1'b0;
				case (cmd)
					CMD_TICK: begin
						sec_q   <= tick_sec;
						min_q   <= tick_min;
						hour_q  <= tick_hour;
						day_q   <= tick_day;
						month_q <= tick_month;
						year_q  <= tick_year;
					end
					CMD_SET: begin
						if (set_bad) begin
							rejected_q <= 1'b1;
						end else begin
							sec_q   <= new_seconds;
							min_q   <= new_minutes;
							hour_q  <= new_hours;
							day_q   <= new_day;
							month_q <= new_month;
							year_q  <= new_year;
						end
					end
					default: begin
					end
				endcase
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_q;
	assign cur_seconds  = sec_q;
	assign cur_minutes  = min_q;
	assign cur_hours    = hour_q;
	assign cur_day      = day_q;
	assign cur_month    = month_q;
	assign cur_year     = year_q;
	assign set_rejected = rejected_q;

endmodule

`default_nettype wire

// File: src/ccc_checker.sv
`default_nettype none

module ccc_checker
	import ccc_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_stall,
	input wire [1:0]          cmd,
	input wire [HOUR_W-1:0]   new_hours,
	input wire                out_valid,
	input wire                out_stall,
	input wire [YEAR_W-1:0]   cur_year,
	input wire                set_rejected
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Every accepted item yields a result on the next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted item gave no result");

	// An out-of-range hour on a set is flagged
	a_bad_hours: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_SET && new_hours > HOUR_MAX
		|=> set_rejected)
		else $error("bad set not flagged");

	// Ticks and reads never flag
	a_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd != CMD_SET |=> !set_rejected)
		else $error("flag on non-set item");

	// A read leaves the year as it was
	a_read_year: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_READ |=> $stable(cur_year))
		else $error("read changed the year");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ccc_pkg::*;

	localparam int CLK_HALF = 2;
	localparam int RESET_CYCLES = 4;
	localparam int IDLE_PCT = 34;
	localparam int QUIET_FROM = 250;
	localparam int QUIET_TO = 350;
	localparam int HOLD_AT = 100;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 10;
	localparam int ITEM_TARGET = 600;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic [SEC_W-1:0]   sec;
		logic [MIN_W-1:0]   min;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} cal_cmd_t;

	typedef struct {
		logic [SEC_W-1:0]   sec;
		logic [MIN_W-1:0]   min;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               rejected;
	} cal_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_READ;
	logic [SEC_W-1:0]   new_seconds = '0;
	logic [MIN_W-1:0]   new_minutes = '0;
	logic [HOUR_W-1:0]  new_hours = '0;
	logic [DAY_W-1:0]   new_day = '0;
	logic [MONTH_W-1:0] new_month = '0;
	logic [YEAR_W-1:0]  new_year = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SEC_W-1:0]   cur_seconds;
	logic [MIN_W-1:0]   cur_minutes;
	logic [HOUR_W-1:0]  cur_hours;
	logic [DAY_W-1:0]   cur_day;
	logic [MONTH_W-1:0] cur_month;
	logic [YEAR_W-1:0]  cur_year;
	logic               set_rejected;

	// Calendar state as the block should hold it; all zero out of reset
	int cal_sec = 0;
	int cal_min = 0;
	int cal_hour = 0;
	int cal_day = 0;
	int cal_month = 0;
	int cal_year = 0;

	cal_cmd_t     pending_cmds[$];
	cal_reading_t expected_readings[$];
	cal_cmd_t     on_bus;
	cal_reading_t want;

	int items_sent = 0;
	int results_seen = 0;
	int err_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	calendar_clock_counter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.new_seconds  (new_seconds),
		.new_minutes  (new_minutes),
		.new_hours    (new_hours),
		.new_day      (new_day),
		.new_month    (new_month),
		.new_year     (new_year),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cur_seconds  (cur_seconds),
		.cur_minutes  (cur_minutes),
		.cur_hours    (cur_hours),
		.cur_day      (cur_day),
		.cur_month    (cur_month),
		.cur_year     (cur_year),
		.set_rejected (set_rejected)
	);

	always #(CLK_HALF) clk = ~clk;

	// Apply one item to the calendar and return the time it leaves behind
	function automatic cal_reading_t apply_cmd(input cal_cmd_t c);
		cal_reading_t r;
		int mlen;
		r.rejected = 1'b0;
		if (c.op == CMD_TICK) begin
			cal_sec = cal_sec + 1;
			if (cal_sec >= SEC_WRAP) begin
				cal_sec = 0;
				// minute step: every check below runs on each step
				cal_min = cal_min + 1;
				if (cal_min >= MIN_WRAP) begin
					cal_min = 0;
					cal_hour = cal_hour + 1;
				end
				if (cal_hour >= HOUR_WRAP) begin
					cal_hour = 0;
					cal_day = cal_day + 1;
				end
				if (cal_month == 4 || cal_month == 6 || cal_month == 9 || cal_month == 11)
					mlen = 30;
				else if (cal_month == 2)
					mlen = (cal_year % 4 == 0) ? 29 : 28;
				else
					mlen = 31;
				if (cal_day > mlen) begin
					cal_day = 1;
					cal_month = cal_month + 1;
				end
				if (cal_month > MONTH_LAST) begin
					cal_month = 1;
					cal_year = (cal_year + 1) & 16'hFFFF;
				end
			end
		end else if (c.op == CMD_SET) begin
			if (c.hour > HOUR_MAX || c.min > MIN_MAX || c.month > MONTH_MAX) begin
				r.rejected = 1'b1;
			end else begin
				cal_sec = int'(c.sec);
				cal_min = int'(c.min);
				cal_hour = int'(c.hour);
				cal_day = int'(c.day);
				cal_month = int'(c.month);
				cal_year = int'(c.year);
			end
		end
		r.sec = cal_sec[SEC_W-1:0];
		r.min = cal_min[MIN_W-1:0];
		r.hour = cal_hour[HOUR_W-1:0];
		r.day = cal_day[DAY_W-1:0];
		r.month = cal_month[MONTH_W-1:0];
		r.year = cal_year[YEAR_W-1:0];
		return r;
	endfunction

	// Queue a non-set item with random payload bits
	task automatic queue_plain(input logic [1:0] op);
		cal_cmd_t c;
		c.op = op;
		c.sec = SEC_W'($urandom);
		c.min = MIN_W'($urandom);
		c.hour = HOUR_W'($urandom);
		c.day = DAY_W'($urandom);
		c.month = MONTH_W'($urandom);
		c.year = YEAR_W'($urandom);
		pending_cmds.push_back(c);
	endtask

	task automatic queue_set(input int s, input int mi, input int h, input int d,
			input int mo, input int y);
		cal_cmd_t c;
		c.op = CMD_SET;
		c.sec = SEC_W'(s);
		c.min = MIN_W'(mi);
		c.hour = HOUR_W'(h);
		c.day = DAY_W'(d);
		c.month = MONTH_W'(mo);
		c.year = YEAR_W'(y);
		pending_cmds.push_back(c);
	endtask

	task automatic check_field(input string name, input logic [YEAR_W-1:0] exp_val,
			input logic [YEAR_W-1:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, exp_val, act_val);
			err_count++;
		end
	endtask

	// Sender: take the next item once the current one is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_readings.push_back(apply_cmd(on_bus));
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() > 0 &&
						((items_sent >= QUIET_FROM && items_sent < QUIET_TO) ||
						$urandom_range(0, 99) >= IDLE_PCT)) begin
					on_bus = pending_cmds.pop_front();
					in_valid <= 1'b1;
					cmd <= on_bus.op;
					new_seconds <= on_bus.sec;
					new_minutes <= on_bus.min;
					new_hours <= on_bus.hour;
					new_day <= on_bus.day;
					new_month <= on_bus.month;
					new_year <= on_bus.year;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d:%0d:%0d",
						$time, cur_hours, cur_minutes, cur_seconds);
					err_count++;
				end else begin
					want = expected_readings.pop_front();
					check_field("cur_seconds", YEAR_W'(want.sec), YEAR_W'(cur_seconds));
					check_field("cur_minutes", YEAR_W'(want.min), YEAR_W'(cur_minutes));
					check_field("cur_hours", YEAR_W'(want.hour), YEAR_W'(cur_hours));
					check_field("cur_day", YEAR_W'(want.day), YEAR_W'(cur_day));
					check_field("cur_month", YEAR_W'(want.month), YEAR_W'(cur_month));
					check_field("cur_year", want.year, cur_year);
					check_field("set_rejected", YEAR_W'(want.rejected),
						YEAR_W'(set_rejected));
				end
				results_seen++;
			end
			// hold off once for a long stretch so the input backs up
			if (results_seen == HOLD_AT && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int pick;
		int burst;
		int yr;
		// reset state, then a plain tick and the unused code
		queue_plain(CMD_READ);
		queue_plain(CMD_TICK);
		queue_plain(CMD_UNUSED);
		// end of year at the top year wraps to year zero
		queue_set(59, 59, 23, 31, 12, 65535);
		queue_plain(CMD_TICK);
		// February in a leap year and a common year
		queue_set(59, 59, 23, 28, 2, 2024);
		queue_plain(CMD_TICK);
		queue_set(59, 59, 23, 29, 2, 2024);
		queue_plain(CMD_TICK);
		queue_set(59, 59, 23, 28, 2, 2023);
		queue_plain(CMD_TICK);
		// end of a 30-day month and of a 31-day month
		queue_set(59, 59, 23, 30, 4, 2023);
		queue_plain(CMD_TICK);
		queue_set(59, 59, 23, 31, 1, 0);
		queue_plain(CMD_TICK);
		// day too large for its month rolls over on the next minute step
		queue_set(59, 59, 0, 31, 4, 7);
		queue_plain(CMD_TICK);
		// seconds loaded above 59
		queue_set(63, 5, 5, 5, 5, 5);
		queue_plain(CMD_TICK);
		// day and month zero: the day leaves zero on a minute step, the month stays zero
		queue_set(59, 59, 23, 0, 0, 0);
		queue_plain(CMD_TICK);
		// rejected loads, then a valid load of all zeros
		queue_set(0, 60, 0, 1, 1, 1);
		queue_set(0, 0, 24, 1, 1, 1);
		queue_set(0, 0, 0, 1, 13, 1);
		queue_set(63, 63, 31, 31, 15, 65535);
		queue_set(0, 0, 0, 0, 0, 0);

		// random part: about half the picks load near a rollover and run a tick burst
		while (pending_cmds.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: yr = $urandom_range(0, 65535);
				1: yr = $urandom_range(65532, 65535);
				2: yr = $urandom_range(0, 16383) * 4;
				default: yr = $urandom_range(1900, 2100);
			endcase
			if (pick < 50) begin
				queue_set($urandom_range(55, 63),
					$urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
					$urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
					$urandom_range(0, 2) != 0 ? $urandom_range(27, 31) : $urandom_range(0, 31),
					$urandom_range(0, 12), yr);
				burst = $urandom_range(1, 10);
				repeat (burst) queue_plain(CMD_TICK);
			end else if (pick < 62) begin
				queue_set($urandom_range(0, 63), $urandom_range(0, 59), $urandom_range(0, 23),
					$urandom_range(0, 31), $urandom_range(0, 12), yr);
				queue_plain(CMD_TICK);
			end else if (pick < 77) begin
				// noise: every field across its whole range
				queue_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else if (pick < 87) begin
				queue_plain($urandom_range(0, 1) ? CMD_READ : CMD_UNUSED);
			end else begin
				burst = $urandom_range(1, 20);
				repeat (burst) queue_plain(CMD_TICK);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all items taken, all results back, then an idle wait
		while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
